/* rtl/rfc_pkg.sv */
`default_nettype none

package rfc_pkg;

    localparam int RFC_DATA_FRAME_LEN = 17;
    localparam int RFC_ACK_FRAME_LEN  = 8;
    localparam int RFC_MARK_POS       = 2;

    // Register indexes on the configuration channel
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ACK_PATTERN = 2'd0;
    localparam t_cfg_idx CFG_ACK_MARKER  = 2'd1;
    localparam t_cfg_idx CFG_DATA_MARKER = 2'd2;

    localparam logic [63:0] RST_ACK_PATTERN = 64'd77218170262556715;
    localparam logic [7:0]  RST_ACK_MARKER  = 8'h55;
    localparam logic [7:0]  RST_DATA_MARKER = 8'h0C;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef struct packed {
        logic [63:0] ack_pattern;
        logic [7:0]  ack_marker;
        logic [7:0]  data_marker;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_byte;
        logic [4:0]  byte_index;
        logic        ack_matched;
        logic [15:0] ack_count;
        logic        last;
    } t_res;

endpackage

`default_nettype wire

/* rtl/rfc_in_if.sv */
`default_nettype none

interface rfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/rfc_out_if.sv */
`default_nettype none

interface rfc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  frame_byte;
    logic [4:0]  byte_index;
    logic        ack_matched;
    logic [15:0] ack_count;
    logic        last;

    modport source (output valid, output kind, output frame_byte, output byte_index,
                    output ack_matched, output ack_count, output last, input ready);
    modport sink   (input valid, input kind, input frame_byte, input byte_index,
                    input ack_matched, input ack_count, input last, output ready);
endinterface

`default_nettype wire

/* rtl/rfc_cfg_if.sv */
`default_nettype none

interface rfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [63:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/rfc_frame_mem.sv */
`default_nettype none

module rfc_frame_mem #(
    parameter int DEPTH  = rfc_pkg::RFC_DATA_FRAME_LEN,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/rfc_ctrl.sv */
`default_nettype none

module rfc_ctrl #(
    parameter int DATA_FRAME_LEN = rfc_pkg::RFC_DATA_FRAME_LEN,
    parameter int ACK_FRAME_LEN  = rfc_pkg::RFC_ACK_FRAME_LEN,
    parameter int ADDR_W         = $clog2(DATA_FRAME_LEN)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rfc_pkg::t_cfg     i_cfg,
    rfc_in_if.sink                 i_rx,
    rfc_out_if.source              o_res,
    output logic                   o_mem_we,
    output logic      [ADDR_W-1:0] o_mem_waddr,
    output logic      [7:0]        o_mem_wdata,
    output logic                   o_mem_re,
    output logic      [ADDR_W-1:0] o_mem_raddr,
    input  wire logic [7:0]        i_mem_rdata
);
    import rfc_pkg::*;

    localparam int POS_W = $clog2(DATA_FRAME_LEN + 1);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_ACK_RD  = 2'd1;
    localparam logic [1:0] S_ACK_OUT = 2'd2;
    localparam logic [1:0] S_DAT_RD  = 2'd3;

    logic [1:0]        r_state,  n_state;
    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [7:0]        r_mark,   n_mark;
    logic [15:0]       r_cnt,    n_cnt;
    logic [POS_W-1:0]  r_k,      n_k;
    logic              r_match,  n_match;
    logic              r_rd_vld, n_rd_vld;
    logic              r_rd_dat, n_rd_dat;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic              r_out_vld, n_out_vld;
    t_res              r_out,    n_out;

    logic [POS_W-1:0]  pos_inc;
    logic [7:0]        mark_now;
    logic              is_ack;
    logic              is_dat;
    logic              out_free;
    logic [2:0]        bsel;
    logic [7:0]        pat_byte;

    assign pos_inc  = r_pos + 1'b1;
    assign mark_now = (r_pos == POS_W'(RFC_MARK_POS)) ? i_rx.rx_byte : r_mark;
    assign is_ack   = (pos_inc == POS_W'(ACK_FRAME_LEN)) && (mark_now == i_cfg.ack_marker);
    assign is_dat   = (pos_inc == POS_W'(DATA_FRAME_LEN)) && (mark_now == i_cfg.data_marker);
    assign out_free = !r_out_vld || o_res.ready;

    // First frame byte sits in the most significant used byte of the pattern
    assign bsel     = 3'(ACK_FRAME_LEN - 1) - 3'(r_rd_idx);
    assign pat_byte = i_cfg.ack_pattern[{bsel, 3'b000} +: 8];

    assign i_rx.ready  = (r_state == S_IDLE);
    assign o_mem_waddr = r_pos[ADDR_W-1:0];
    assign o_mem_wdata = i_rx.rx_byte;
    assign o_mem_raddr = r_k[ADDR_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_mark    = r_mark;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_match   = r_match;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_res.ready;
        o_mem_we  = 1'b0;
        o_mem_re  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_rx.valid) begin
                    o_mem_we = 1'b1;
                    n_mark   = mark_now;
                    priority if (is_ack) begin
                        n_state = S_ACK_RD;
                        n_k     = '0;
                        n_match = 1'b1;
                        n_pos   = '0;
                    end else if (is_dat) begin
                        n_state = S_DAT_RD;
                        n_k     = '0;
                        n_pos   = '0;
                    end else if (pos_inc == POS_W'(DATA_FRAME_LEN)) begin
                        n_pos = '0;
                    end else begin
                        n_pos = pos_inc;
                    end
                end
            end
            S_ACK_RD: begin
                // One byte read per cycle, compare as the data returns
                if (r_k < POS_W'(ACK_FRAME_LEN)) begin
                    o_mem_re = 1'b1;
                    n_k      = r_k + 1'b1;
                end
                if (r_rd_vld) begin
                    n_match = r_match && (i_mem_rdata == pat_byte);
                    if (r_rd_idx == ADDR_W'(ACK_FRAME_LEN - 1)) begin
                        n_state = S_ACK_OUT;
                    end
                end
            end
            S_ACK_OUT: begin
                if (out_free) begin
                    n_cnt             = r_cnt + 16'(r_match);
                    n_out.kind        = KIND_ACK;
                    n_out.frame_byte  = '0;
                    n_out.byte_index  = '0;
                    n_out.ack_matched = r_match;
                    n_out.ack_count   = r_cnt + 16'(r_match);
                    n_out.last        = 1'b1;
                    n_out_vld         = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_DAT_RD: begin
                // Issue a read only when its byte can land in the output register
                if (!r_rd_vld && out_free) begin
                    o_mem_re = 1'b1;
                    n_k      = r_k + 1'b1;
                    if (r_k == POS_W'(DATA_FRAME_LEN - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Data byte returning from memory goes straight to the output register
        if (r_rd_vld && r_rd_dat) begin
            n_out.kind        = KIND_DATA;
            n_out.frame_byte  = i_mem_rdata;
            n_out.byte_index  = 5'(r_rd_idx);
            n_out.ack_matched = 1'b0;
            n_out.ack_count   = r_cnt;
            n_out.last        = (r_rd_idx == ADDR_W'(DATA_FRAME_LEN - 1));
            n_out_vld         = 1'b1;
        end

        n_rd_vld = o_mem_re;
        n_rd_dat = (r_state == S_DAT_RD);
        n_rd_idx = o_mem_re ? r_k[ADDR_W-1:0] : r_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_cnt     <= n_cnt;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mark   <= n_mark;
        r_k      <= n_k;
        r_match  <= n_match;
        r_rd_dat <= n_rd_dat;
        r_rd_idx <= n_rd_idx;
        r_out    <= n_out;
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.kind        = r_out.kind;
    assign o_res.frame_byte  = r_out.frame_byte;
    assign o_res.byte_index  = r_out.byte_index;
    assign o_res.ack_matched = r_out.ack_matched;
    assign o_res.ack_count   = r_out.ack_count;
    assign o_res.last        = r_out.last;

endmodule

`default_nettype wire

/* rtl/response_frame_classifier.sv */
`default_nettype none

// Channel   Dir  Payload                                       Transfer
// i_rx      in   rx_byte[7:0]                                  valid && ready
// o_res     out  kind, frame_byte, byte_index, ack_matched,    valid && ready
//                ack_count[15:0], last
// i_cfg     in   reg_index[1:0], wdata[63:0]                   valid && ready
//
// An input byte is written to the frame memory at the running position.
// An acknowledge check reads ACK_FRAME_LEN bytes, one per cycle over the
// single read port, then posts its result once the output register is free.
// A data frame is read out one byte at a time, since each read waits for
// the previous byte to leave the output register, so a stalling sink slows it.
// Reset is synchronous, active low; it clears position, match counter,
// configuration and handshake state. The frame memory is not cleared.
// The output register holds its result while the sink stalls; no input
// is taken while a check or readout is running.
module response_frame_classifier #(
    parameter int DATA_FRAME_LEN = rfc_pkg::RFC_DATA_FRAME_LEN,
    parameter int ACK_FRAME_LEN  = rfc_pkg::RFC_ACK_FRAME_LEN
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rfc_in_if.sink    i_rx,
    rfc_out_if.source o_res,
    rfc_cfg_if.sink   i_cfg
);
    import rfc_pkg::*;

    localparam int ADDR_W = $clog2(DATA_FRAME_LEN);

    t_cfg r_cfg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    // Configuration writes are always taken; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_pattern <= RST_ACK_PATTERN;
            r_cfg.ack_marker  <= RST_ACK_MARKER;
            r_cfg.data_marker <= RST_DATA_MARKER;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_ACK_PATTERN: r_cfg.ack_pattern <= i_cfg.wdata;
                CFG_ACK_MARKER:  r_cfg.ack_marker  <= i_cfg.wdata[7:0];
                CFG_DATA_MARKER: r_cfg.data_marker <= i_cfg.wdata[7:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Frame bytes live in one synchronous memory
    rfc_frame_mem #(
        .DEPTH  (DATA_FRAME_LEN),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Sequencer: capture, acknowledge check, data readout, output register
    rfc_ctrl #(
        .DATA_FRAME_LEN (DATA_FRAME_LEN),
        .ACK_FRAME_LEN  (ACK_FRAME_LEN),
        .ADDR_W         (ADDR_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rx        (i_rx),
        .o_res       (o_res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
